FILE: src/eu_dst_utc_offset_unit_defines.svh
// Assertion macros used by the RTL of the summer time unit.
// Define NO_ASSERTIONS to compile them out.
`ifndef EU_DST_UTC_OFFSET_UNIT_DEFINES_SVH
`define EU_DST_UTC_OFFSET_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// ante true at an edge implies cons at the same edge
`define EUDST_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("eudst assertion failed");

// ante true at an edge implies cons at the next edge
`define EUDST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("eudst assertion failed");

`else

`define EUDST_ASSERT_IMPL(label, ante, cons)
`define EUDST_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/eudst_pkg.sv
package eudst_pkg;

   localparam int unsigned TIME_W = 32;

   localparam logic [TIME_W-1:0] EPOCH_2000       = 32'd946684800;
   localparam logic [TIME_W-1:0] LAST_VALID       = 32'd4102444799;
   localparam logic [TIME_W-1:0] SECS_PER_DAY     = 32'd86400;
   localparam logic [TIME_W-1:0] SECS_PER_HOUR    = 32'd3600;
   localparam logic [TIME_W-1:0] QUAD_SECS        = 32'd126230400;
   localparam logic [TIME_W-1:0] LEAP_YEAR_SECS   = 32'd31622400;
   localparam logic [TIME_W-1:0] COMMON_YEAR_SECS = 32'd31536000;

   localparam logic [4:0] QUAD_MAX = 5'd24;
   localparam logic [1:0] YEAR_MAX = 2'd3;

   localparam logic [8:0] MAR31_DOY = 9'd89;
   localparam logic [8:0] OCT31_DOY = 9'd303;

   // weekdays with Sunday = 0; the year 2000 opens on a Saturday
   localparam logic [2:0] SAT_WEEKDAY    = 3'd6;
   localparam logic [2:0] QUAD_WD_STEP   = 3'd5;
   localparam logic [2:0] LEAP_WD_STEP   = 3'd2;
   localparam logic [2:0] COMMON_WD_STEP = 3'd1;
   localparam logic [2:0] MAR31_WD_STEP  = 3'd5;
   localparam logic [2:0] OCT31_WD_STEP  = 3'd2;

   localparam logic [12:0] STD_OFFSET    = 13'd3600;
   localparam logic [12:0] SUMMER_OFFSET = 13'd7200;

   typedef struct packed {
      logic [TIME_W-1:0] diff;
      logic              ge;
   } eudst_sub_type;

   function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
      logic [3:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= 4'd7) begin
         sum = sum - 4'd7;
      end
      return sum[2:0];
   endfunction

endpackage

FILE: src/eudst_sub.sv
module eudst_sub (
   input  logic [eudst_pkg::TIME_W-1:0] minuend,
   input  logic [eudst_pkg::TIME_W-1:0] subtrahend,
   output eudst_pkg::eudst_sub_type     result
);
   import eudst_pkg::*;

   logic [TIME_W:0] wide_diff;

   assign wide_diff   = {1'b0, minuend} - {1'b0, subtrahend};
   assign result.diff = wide_diff[TIME_W-1:0];
   assign result.ge   = ~wide_diff[TIME_W];

endmodule

FILE: src/eu_dst_utc_offset_unit.sv
// Per word the sequencer takes off the 2000 epoch, steps through four-year blocks and years
// on the shared subtractor, then builds and compares the March and October change instants.
// Throughput: one word at a time; the next word is taken in idle, which the sequencer enters
// as the result is registered. A result still waiting in the output register holds the
// sequencer in its last step, and the next word then waits as long.
// Reset: synchronous, active high; clears the sequencer and the result valid.
`include "eu_dst_utc_offset_unit_defines.svh"

module eu_dst_utc_offset_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_utc_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_offset_seconds,
   output logic        rsp_summer_time
);
   import eudst_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_QUAD,
      ST_YEAR,
      ST_MAR_OFF,
      ST_MAR_CMP,
      ST_OCT_OFF,
      ST_OCT_CMP
   } state_type;

   state_type         state_ff, state_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [4:0]        quad_ff, quad_in;
   logic [1:0]        year_ff, year_in;
   logic [2:0]        wd_ff, wd_in;
   logic [TIME_W-1:0] off_ff, off_in;
   logic              after_start_ff, after_start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [12:0]       rsp_offset_ff, rsp_offset_in;
   logic              rsp_summer_ff, rsp_summer_in;

   logic              req_accept;
   logic              leap;
   logic [TIME_W-1:0] operand;
   eudst_sub_type     sub_res;
   logic [8:0]        mar_day;
   logic [8:0]        oct_day;
   logic              summer;

   eudst_sub u_sub (
      .minuend    (rem_ff),
      .subtrahend (operand),
      .result     (sub_res)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign leap       = (year_ff == 2'd0);

   // day of year of the last Sunday of March and of October
   assign mar_day = MAR31_DOY + 9'(leap) - 9'(add_mod7(wd_ff, MAR31_WD_STEP + 3'(leap)));
   assign oct_day = OCT31_DOY + 9'(leap) - 9'(add_mod7(wd_ff, OCT31_WD_STEP + 3'(leap)));

   assign summer = after_start_ff && !sub_res.ge;

   always_comb begin
      case (state_ff)
         ST_SHIFT:   operand = EPOCH_2000;
         ST_QUAD:    operand = QUAD_SECS;
         ST_YEAR:    operand = leap ? LEAP_YEAR_SECS : COMMON_YEAR_SECS;
         ST_MAR_CMP: operand = off_ff;
         ST_OCT_CMP: operand = off_ff;
         default:    operand = '0;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      rem_in         = rem_ff;
      quad_in        = quad_ff;
      year_in        = year_ff;
      wd_in          = wd_ff;
      off_in         = off_ff;
      after_start_in = after_start_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_offset_in  = rsp_offset_ff;
      rsp_summer_in  = rsp_summer_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rem_in   = (req_utc_seconds > LAST_VALID) ? LAST_VALID : req_utc_seconds;
               quad_in  = '0;
               year_in  = '0;
               wd_in    = SAT_WEEKDAY;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // clamp low: anything before 2000 starts at zero
            rem_in   = sub_res.ge ? sub_res.diff : '0;
            state_in = ST_QUAD;
         end
         ST_QUAD: begin
            if (quad_ff < QUAD_MAX && sub_res.ge) begin
               rem_in  = sub_res.diff;
               quad_in = quad_ff + 5'd1;
               wd_in   = add_mod7(wd_ff, QUAD_WD_STEP);
            end else begin
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (year_ff < YEAR_MAX && sub_res.ge) begin
               rem_in  = sub_res.diff;
               year_in = year_ff + 2'd1;
               wd_in   = add_mod7(wd_ff, leap ? LEAP_WD_STEP : COMMON_WD_STEP);
            end else begin
               state_in = ST_MAR_OFF;
            end
         end
         ST_MAR_OFF: begin
            off_in   = 32'(mar_day) * SECS_PER_DAY + SECS_PER_HOUR;
            state_in = ST_MAR_CMP;
         end
         ST_MAR_CMP: begin
            after_start_in = sub_res.ge;
            state_in       = ST_OCT_OFF;
         end
         ST_OCT_OFF: begin
            off_in   = 32'(oct_day) * SECS_PER_DAY + SECS_PER_HOUR;
            state_in = ST_OCT_CMP;
         end
         ST_OCT_CMP: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_summer_in = summer;
               rsp_offset_in = summer ? SUMMER_OFFSET : STD_OFFSET;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff         <= rem_in;
      quad_ff        <= quad_in;
      year_ff        <= year_in;
      wd_ff          <= wd_in;
      off_ff         <= off_in;
      after_start_ff <= after_start_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_summer_ff  <= rsp_summer_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_offset_seconds = rsp_offset_ff;
   assign rsp_summer_time    = rsp_summer_ff;

   `EUDST_ASSERT_NEXT(a_accept_starts, req_accept, state_ff == ST_SHIFT)
   `EUDST_ASSERT_IMPL(a_quad_range, state_ff == ST_QUAD, quad_ff <= QUAD_MAX)
   `EUDST_ASSERT_IMPL(a_year_rem, state_ff == ST_YEAR, rem_ff < QUAD_SECS)
   `EUDST_ASSERT_IMPL(a_weekday_range, state_ff == ST_MAR_OFF, wd_ff < 3'd7)

endmodule
